// ----- rtl/core/dotp_pkg.sv -----
// types, codes and option length rules shared by the dhcp option parser
`timescale 1ns / 1ps
`default_nettype none
package dotp_pkg;

	typedef enum logic [1:0] {
		PH_CODE   = 2'd0,
		PH_LENGTH = 2'd1,
		PH_VALUE  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_PAD     = 3'd0,
		ROLE_CODE    = 3'd1,
		ROLE_LENGTH  = 3'd2,
		ROLE_VALUE   = 3'd3,
		ROLE_END     = 3'd4,
		ROLE_IGNORED = 3'd5
	} role_t;

	localparam logic [7:0] OPT_PAD         = 8'd0;
	localparam logic [7:0] OPT_SUBNET_MASK = 8'd1;
	localparam logic [7:0] OPT_ROUTER      = 8'd3;
	localparam logic [7:0] OPT_TIME_SERVER = 8'd4;
	localparam logic [7:0] OPT_DNS         = 8'd6;
	localparam logic [7:0] OPT_HOST_NAME   = 8'd12;
	localparam logic [7:0] OPT_DOMAIN_NAME = 8'd15;
	localparam logic [7:0] OPT_NTP         = 8'd42;
	localparam logic [7:0] OPT_MSG_TYPE    = 8'd53;
	localparam logic [7:0] OPT_END         = 8'd255;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] code;
		logic [7:0] left;
		logic [7:0] pos;
		logic       len_ok;
		logic       finished;
	} parse_state_t;

	localparam parse_state_t STATE_CLEAR = '{
		phase: PH_CODE, code: 8'd0, left: 8'd0, pos: 8'd0, len_ok: 1'b0, finished: 1'b0
	};

	typedef struct packed {
		role_t      role;
		logic [7:0] code;
		logic [7:0] index;
		logic [7:0] value;
		logic       valid;
		logic       done;
		logic       truncated;
	} parse_result_t;

	function automatic logic legal_length(input logic [7:0] code, input logic [7:0] len);
		logic ok;
		case (code)
			OPT_SUBNET_MASK: ok = (len == 8'd4);
			OPT_ROUTER, OPT_TIME_SERVER, OPT_DNS, OPT_NTP: ok = (len[1:0] == 2'b00);
			OPT_HOST_NAME, OPT_DOMAIN_NAME: ok = 1'b1;
			OPT_MSG_TYPE: ok = (len == 8'd1);
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dhcp_option_tlv_parser.sv -----
// top level of the dhcp options area parser: input stage, parse state, result register
`timescale 1ns / 1ps
`default_nettype none
// Walks the options area of a DHCP message one byte per request and returns
// one result per byte: its role (pad, code, length, value, end, ignored), the
// option code it belongs to, its index in the value, the byte itself, whether
// the option is known with a legal length, and on the byte where parsing ends
// a done flag (tlast) plus a truncated flag when the area stopped inside an
// option. s_tuser marks the first byte of a new area and clears the parse
// state; s_tlast marks the last byte the length budget allows. After the end
// option or the last byte, bytes are reported as ignored until a new area
// starts. Rate: one byte per cycle while m_tready does not hold the result
// register back. Each byte passes through an input register, one short
// combinational parse step that also updates the state, and a result
// register.
module dhcp_option_tlv_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tuser,  // [0] first_byte
	input  wire logic        s_tlast,  // last_byte
	// result stream
	output wire logic        m_tvalid,
	input  wire logic        m_tready,
	output wire logic [31:0] m_tdata,  // [7:0] option_code, [15:8] value_index,
	                                   // [23:16] value_byte, [24] truncated, rest zero
	output wire logic [3:0]  m_tuser,  // [2:0] byte_role, [3] value_valid
	output wire logic        m_tlast   // done_res
);
	import dotp_pkg::*;

	// input stage
	logic       vld_s1;
	logic [7:0] data_s1;
	logic       first_s1;
	logic       last_s1;

	// result register
	logic          vld_s2;
	parse_result_t res_s2;

	// parse state
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;

	logic advance;

	// the parse step fires when the result register is free or draining
	assign advance  = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	dotp_step u_step (
		.cur        (state_q),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.last_byte  (last_s1),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {7'd0, res_s2.truncated, res_s2.value, res_s2.index, res_s2.code};
	assign m_tuser  = {res_s2.valid, res_s2.role};
	assign m_tlast  = res_s2.done;

	// a held input request is not lost while the result side stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !advance |=> vld_s1 && $stable(data_s1))
		else $error("input stage dropped a stalled request");

	// only value bytes can be flagged valid or carry a nonzero index
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] != ROLE_VALUE) |-> !m_tuser[3] && (m_tdata[15:8] == 8'd0))
		else $error("non-value byte marked as value");

	// truncation is reported only on the ending byte
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[24] |-> m_tlast)
		else $error("truncated without done");

	// the end option always closes the area cleanly
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == ROLE_END) |-> m_tlast && !m_tdata[24])
		else $error("end option not reported as clean finish");

	// once an ending byte is taken the parser holds finished until a new area
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.done |=> state_q.finished)
		else $error("parse did not stop at ending byte");

endmodule
`default_nettype wire

// ----- rtl/core/dotp_step.sv -----
// one byte of option parsing: classifies the byte and forms the next parse state
`timescale 1ns / 1ps
`default_nettype none
module dotp_step (
	input  var dotp_pkg::parse_state_t  cur,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   first_byte,
	input  wire logic                   last_byte,
	output var dotp_pkg::parse_state_t  nxt,
	output var dotp_pkg::parse_result_t res
);
	import dotp_pkg::*;

	parse_state_t st;
	logic [7:0]   left_dec;

	// a new area starts from a clean state
	assign st       = first_byte ? STATE_CLEAR : cur;
	assign left_dec = st.left - 8'd1;

	always_comb begin
		nxt = st;
		res = '{role: ROLE_IGNORED, code: 8'd0, index: 8'd0, value: 8'd0,
			valid: 1'b0, done: 1'b0, truncated: 1'b0};
		if (!st.finished) begin
			case (st.phase)
				PH_LENGTH: begin
					res.role   = ROLE_LENGTH;
					res.code   = st.code;
					res.done   = last_byte;
					nxt.len_ok = legal_length(st.code, data_byte);
					nxt.left   = data_byte;
					nxt.pos    = 8'd0;
					if (data_byte == 8'd0) begin
						nxt.phase = PH_CODE;
					end else begin
						nxt.phase     = PH_VALUE;
						res.truncated = last_byte;
					end
				end
				PH_VALUE: begin
					res.role  = ROLE_VALUE;
					res.code  = st.code;
					res.index = st.pos;
					res.value = data_byte;
					res.valid = st.len_ok;
					res.done  = last_byte;
					nxt.pos   = st.pos + 8'd1;
					nxt.left  = left_dec;
					if (left_dec == 8'd0) begin
						nxt.phase = PH_CODE;
					end else begin
						res.truncated = last_byte;
					end
				end
				default: begin
					// expecting a code; the unused phase lands here too
					if (data_byte == OPT_PAD) begin
						res.role = ROLE_PAD;
						res.done = last_byte;
					end else if (data_byte == OPT_END) begin
						res.role = ROLE_END;
						res.code = OPT_END;
						res.done = 1'b1;
					end else begin
						res.role      = ROLE_CODE;
						res.code      = data_byte;
						res.truncated = last_byte;
						res.done      = last_byte;
						nxt.code      = data_byte;
						nxt.phase     = PH_LENGTH;
					end
				end
			endcase
			if (res.done) begin
				nxt.finished = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- verif/dhcp_option_tlv_parser_test.sv -----
// self-checking stream testbench for the dhcp options area parser
`timescale 1ns / 1ps
module dhcp_option_tlv_parser_test;
	import dotp_pkg::*;

	localparam int STALL_LIMIT = 2000; // cycles with no request on either side
	localparam int HOLD_CYCLES = 300;  // long result back-pressure stretch
	localparam int RANDOM_BYTES = 275; // random bytes per idling phase
	localparam logic [7:0] KNOWN_CODES [8] = '{OPT_SUBNET_MASK, OPT_ROUTER,
		OPT_TIME_SERVER, OPT_DNS, OPT_HOST_NAME, OPT_DOMAIN_NAME, OPT_NTP, OPT_MSG_TYPE};

	// one byte of an options area as offered on the input stream
	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       last;
	} area_byte_t;

	// what the parser should report for one byte
	typedef struct {
		role_t      role;
		logic [7:0] code;
		logic [7:0] index;
		logic [7:0] value;
		logic       valid;
		logic       done;
		logic       trunc;
	} byte_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire logic   s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	wire logic   m_tvalid;
	logic        m_tready = 1'b0;
	wire logic [31:0] m_tdata;
	wire logic [3:0]  m_tuser;
	wire logic   m_tlast;

	area_byte_t   area_bytes[$];       // bytes waiting to be offered
	byte_report_t expected_reports[$]; // reports owed by the parser, oldest first
	int           bytes_queued = 0;
	int           bytes_accepted = 0;
	int           error_count = 0;
	int           stall_cycles = 0;
	int           send_idle_pct = 35;
	int           recv_idle_pct = 50;
	int           hold_seq = 0;        // bumped to ask the receiver for a long hold
	int           hold_seen = 0;
	int           hold_left = 0;
	logic         in_taken = 1'b0;     // input request completed at the last rising edge

	// shadow copy of the parse state
	phase_t     sh_phase = PH_CODE;
	logic [7:0] sh_code = 8'd0;
	logic [7:0] sh_left = 8'd0;
	logic [7:0] sh_pos = 8'd0;
	logic       sh_len_ok = 1'b0;
	logic       sh_finished = 1'b0;

	dhcp_option_tlv_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// length rule per known option, anything else is never valid
	function automatic logic length_is_legal(input logic [7:0] code, input logic [7:0] len);
		case (code)
			OPT_SUBNET_MASK: return len == 8'd4;
			OPT_ROUTER, OPT_TIME_SERVER, OPT_DNS, OPT_NTP: return len[1:0] == 2'b00;
			OPT_HOST_NAME, OPT_DOMAIN_NAME: return 1'b1;
			OPT_MSG_TYPE: return len == 8'd1;
			default: return 1'b0;
		endcase
	endfunction

	// classify one accepted byte, advance the shadow state, owe its report
	task automatic classify_byte(input logic [7:0] d, input logic first, input logic last);
		byte_report_t r;
		r = '{role: ROLE_IGNORED, code: 8'd0, index: 8'd0, value: 8'd0,
			valid: 1'b0, done: 1'b0, trunc: 1'b0};
		if (first) begin
			sh_phase = PH_CODE;
			sh_code = 8'd0;
			sh_left = 8'd0;
			sh_pos = 8'd0;
			sh_len_ok = 1'b0;
			sh_finished = 1'b0;
		end
		if (!sh_finished) begin
			case (sh_phase)
				PH_LENGTH: begin
					r.role = ROLE_LENGTH;
					r.code = sh_code;
					sh_len_ok = length_is_legal(sh_code, d);
					sh_left = d;
					sh_pos = 8'd0;
					// zero length goes straight back to a code, never truncated
					if (d == 8'd0) begin
						sh_phase = PH_CODE;
					end else begin
						sh_phase = PH_VALUE;
						r.trunc = last;
					end
					r.done = last;
				end
				PH_VALUE: begin
					r.role = ROLE_VALUE;
					r.code = sh_code;
					r.index = sh_pos;
					r.value = d;
					r.valid = sh_len_ok;
					sh_pos = sh_pos + 8'd1;
					sh_left = sh_left - 8'd1;
					if (sh_left == 8'd0)
						sh_phase = PH_CODE;
					else
						r.trunc = last;
					r.done = last;
				end
				default: begin
					// expecting a code: pad, end option or a new option
					if (d == OPT_PAD) begin
						r.role = ROLE_PAD;
						r.done = last;
					end else if (d == OPT_END) begin
						r.role = ROLE_END;
						r.code = OPT_END;
						r.done = 1'b1;
					end else begin
						r.role = ROLE_CODE;
						r.code = d;
						sh_code = d;
						sh_phase = PH_LENGTH;
						r.trunc = last;
						r.done = last;
					end
				end
			endcase
			if (r.done)
				sh_finished = 1'b1;
		end
		expected_reports.push_back(r);
	endtask

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// rising edge: check completed result requests, then predict accepted input requests
	always @(posedge clk) begin : track_requests
		byte_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result: tdata %h tuser %h tlast %b", m_tdata, m_tuser,
					m_tlast);
				error_count++;
			end else begin
				want = expected_reports.pop_front();
				check_field("byte_role", want.role, m_tuser[2:0]);
				check_field("option_code", want.code, m_tdata[7:0]);
				check_field("value_index", want.index, m_tdata[15:8]);
				check_field("value_byte", want.value, m_tdata[23:16]);
				check_field("value_valid", want.valid, m_tuser[3]);
				check_field("done_res", want.done, m_tlast);
				check_field("truncated", want.trunc, m_tdata[24]);
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			classify_byte(s_tdata, s_tuser, s_tlast);
			bytes_accepted++;
		end
		in_taken <= arst_n && s_tvalid && s_tready;
		// watchdog on requests of either side
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** dhcp_option_tlv_parser: FAILED **");
			$finish;
		end
	end

	// falling edge: offer the next byte once the current one is taken
	always @(negedge clk) begin : drive_bytes
		area_byte_t nb;
		if (arst_n && (!s_tvalid || in_taken)) begin
			if (area_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nb = area_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nb.data;
				s_tuser <= nb.first;
				s_tlast <= nb.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// falling edge: result back-pressure, random or a long hold on request
	always @(negedge clk) begin : pace_results
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void add_byte(input logic [7:0] d, input logic first, input logic last);
		area_byte_t b;
		b.data = d;
		b.first = first;
		b.last = last;
		area_bytes.push_back(b);
		bytes_queued++;
	endfunction

	// mostly lengths that suit the option, some arbitrary, a few long ones
	function automatic logic [7:0] pick_length(input logic [7:0] code);
		int r;
		r = $urandom_range(99);
		if (r >= 98)
			return 8'($urandom_range(10, 255));
		if (r >= 60)
			return 8'($urandom_range(0, 9));
		case (code)
			OPT_SUBNET_MASK: return 8'd4;
			OPT_ROUTER, OPT_TIME_SERVER, OPT_DNS, OPT_NTP: return 8'(4 * $urandom_range(0, 3));
			OPT_HOST_NAME, OPT_DOMAIN_NAME: return 8'($urandom_range(0, 8));
			OPT_MSG_TYPE: return 8'd1;
			default: return 8'($urandom_range(0, 6));
		endcase
	endfunction

	// one well-formed area with random options, ended one of four ways
	function automatic void queue_area();
		logic [7:0] area[$];
		logic [7:0] code;
		logic [7:0] len;
		int ending;
		int stop_at;
		int trail;
		repeat ($urandom_range(1, 5)) begin
			if ($urandom_range(9) == 0) begin
				area.push_back(OPT_PAD);
			end else begin
				if ($urandom_range(9) < 7)
					code = KNOWN_CODES[$urandom_range(7)];
				else
					code = 8'($urandom_range(1, 254));
				len = pick_length(code);
				area.push_back(code);
				area.push_back(len);
				repeat (len)
					area.push_back(8'($urandom_range(255)));
			end
		end
		ending = $urandom_range(3);
		stop_at = -1;
		trail = 0;
		case (ending)
			0: begin
				// end option, then bytes that must be ignored
				area.push_back(OPT_END);
				trail = $urandom_range(0, 3);
			end
			1: stop_at = area.size() - 1;                   // budget ends on the last byte
			2: stop_at = $urandom_range(0, area.size() - 1); // budget cuts the area short
			default: ;                                       // next area simply starts
		endcase
		foreach (area[i]) begin
			if (stop_at < 0 || i <= stop_at)
				add_byte(area[i], i == 0, i == stop_at);
		end
		repeat (trail)
			add_byte(8'($urandom_range(255)), 1'b0, $urandom_range(3) == 0);
	endfunction

	// random traffic: mostly well-formed areas, some loose noise bytes
	function automatic void queue_random(input int count);
		int target;
		target = bytes_queued + count;
		while (bytes_queued < target) begin
			if ($urandom_range(99) < 80)
				queue_area();
			else
				add_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
					$urandom_range(7) == 0);
		end
	endfunction

	// sender pause until every byte is taken and every report has come back
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || expected_reports.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: message type with the largest value byte
		add_byte(OPT_PAD, 1'b1, 1'b0);
		add_byte(OPT_MSG_TYPE, 1'b0, 1'b0);
		add_byte(8'd1, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b0);
		// subnet mask with legal length
		add_byte(OPT_SUBNET_MASK, 1'b0, 1'b0);
		add_byte(8'd4, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'hff, 1'b0, 1'b0);
		add_byte(8'haa, 1'b0, 1'b0);
		add_byte(8'h55, 1'b0, 1'b0);
		// unknown option with zero length, router with illegal length
		add_byte(8'd200, 1'b0, 1'b0);
		add_byte(8'd0, 1'b0, 1'b0);
		add_byte(OPT_ROUTER, 1'b0, 1'b0);
		add_byte(8'd3, 1'b0, 1'b0);
		add_byte(8'h80, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b0);
		add_byte(8'h7f, 1'b0, 1'b0);
		// end option, then a byte after the end
		add_byte(OPT_END, 1'b0, 1'b0);
		add_byte(8'h12, 1'b0, 1'b1);
		// last byte on a code
		add_byte(OPT_HOST_NAME, 1'b1, 1'b1);
		// last byte on a zero length
		add_byte(OPT_DOMAIN_NAME, 1'b1, 1'b0);
		add_byte(8'd0, 1'b0, 1'b1);
		// last byte on a nonzero length
		add_byte(OPT_DNS, 1'b1, 1'b0);
		add_byte(8'd8, 1'b0, 1'b1);
		// last byte inside a value, then a pad that ends an area
		add_byte(OPT_NTP, 1'b1, 1'b0);
		add_byte(8'd8, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b1);
		add_byte(OPT_PAD, 1'b1, 1'b1);

		queue_random(RANDOM_BYTES);
		wait_drained();

		send_idle_pct = 50;
		recv_idle_pct = 35;
		queue_random(RANDOM_BYTES);
		wait_drained();

		// no idling, with one long hold on the result side to fill the pipe
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_seq++;
		queue_random(RANDOM_BYTES);
		wait_drained();

		repeat (16) @(negedge clk);
		if (error_count == 0 && expected_reports.size() == 0)
			$display("** dhcp_option_tlv_parser: PASSED **");
		else
			$display("** dhcp_option_tlv_parser: FAILED **");
		$finish;
	end

endmodule
